// File: design/rpad_pkg.sv
`default_nettype none

package rpad_pkg;

    // Command codes carried in tuser on the input side
    typedef logic [0:0] cmd_t;
    localparam cmd_t CMD_START    = 1'b0;
    localparam cmd_t CMD_CONTINUE = 1'b1;

    // Pad modes held in the pad_mode register
    typedef logic [2:0] pad_mode_t;
    localparam pad_mode_t MODE_NONE    = 3'd0;
    localparam pad_mode_t MODE_STICK1  = 3'd1;
    localparam pad_mode_t MODE_STICK2  = 3'd2;
    localparam pad_mode_t MODE_STICK3  = 3'd3;
    localparam pad_mode_t MODE_GEN3    = 3'd4;
    localparam pad_mode_t MODE_GEN5    = 3'd5;
    localparam pad_mode_t MODE_GEN6    = 3'd6;
    localparam pad_mode_t MODE_CD32    = 3'd7;

    // Register indexes of the configuration port
    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_PAD_MODE = 1'b0;

    // Pin positions in pin_levels
    localparam int PIN_UP    = 0;
    localparam int PIN_DOWN  = 1;
    localparam int PIN_LEFT  = 2;
    localparam int PIN_RIGHT = 3;
    localparam int PIN_FIRE1 = 4;
    localparam int PIN_FIRE2 = 5;
    localparam int PIN_FIRE3 = 6;

    // Button mask bits
    typedef logic [9:0] buttons_t;
    localparam buttons_t BIT_A     = 10'h001;
    localparam buttons_t BIT_B     = 10'h002;
    localparam buttons_t BIT_C     = 10'h004;
    localparam buttons_t BIT_X     = 10'h008;
    localparam buttons_t BIT_Y     = 10'h010;
    localparam buttons_t BIT_Z     = 10'h020;
    localparam buttons_t BIT_START = 10'h040;
    localparam buttons_t BIT_MODE  = 10'h080;
    localparam buttons_t BIT_TL    = 10'h100;
    localparam buttons_t BIT_TR    = 10'h200;

    typedef logic [4:0] step_t;
    localparam step_t STEP_IDLE      = 5'd0;
    localparam step_t STEP_FIRST     = 5'd1;
    localparam step_t STEP_SECOND    = 5'd2;
    localparam step_t STEP_SHIFT0    = 5'd3;
    localparam step_t STEP_G6_EXTRA  = 5'd5;
    localparam step_t STEP_G6_LAST   = 5'd7;
    localparam step_t STEP_CD32_LAST = 5'd16;

    // Order in which the CD32 pad shifts out its buttons
    function automatic buttons_t cd32_bit(input logic [2:0] idx);
        buttons_t b;
        case (idx)
            3'd0:    b = BIT_A;
            3'd1:    b = BIT_B;
            3'd2:    b = BIT_X;
            3'd3:    b = BIT_Y;
            3'd4:    b = BIT_TR;
            3'd5:    b = BIT_TL;
            3'd6:    b = BIT_START;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/retro_pad_poll_sequencer_unit.sv
`default_nettype none

// Poll sequencer for one DB9 game-controller port. Send a start item (tuser 0)
// to begin a poll, then one continue item (tuser 1) per step carrying the pin
// levels sampled after the previous result's select drive has settled. Each
// result gives the select levels to drive and a busy flag; the result that
// ends the poll has tuser set and carries directions and the button mask.
// Steps per poll: multistick 1, 3/5-button pad 2, 6-button pad 7, CD32 16.
// One item is taken every clock cycle unless the result stream stalls; an
// item is held in the input register and its result in the output register.
// The pad mode is written over the APB port at byte address 0 and should
// only change while no poll step is in flight.
module retro_pad_poll_sequencer_unit
    import rpad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [6:0] pin_levels, [7] zero
    input  wire logic        s_axis_tuser,  // [0] command
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // [0] select_zero, [1] select_one,
                                            // [2] busy_res, [4:3] x_direction,
                                            // [6:5] y_direction,
                                            // [16:7] button_mask, [23:17] zero
    output logic             m_axis_tuser   // [0] report_valid
);

    // Configuration
    pad_mode_t pad_mode_reg;
    logic      cfg_wr;

    // Input register
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [6:0] in_pins_reg;

    // Poll state
    step_t       step_reg, step_next;
    logic        sel0_reg, sel0_next;
    logic        sel1_reg, sel1_next;
    buttons_t    btn_reg, btn_next;
    logic [1:0]  hx_reg, hx_next;
    logic [1:0]  hy_reg, hy_next;

    // Output register
    logic        out_valid_reg;
    logic [16:0] out_data_reg;
    logic        out_report_reg;

    // Step logic
    logic        advance;
    logic        take;
    logic        busy;
    logic        report;
    logic        done;
    logic        abort;
    logic [6:0]  prs;
    logic [1:0]  dx;
    logic [1:0]  dy;
    step_t       k;
    logic [16:0] res_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PAD_MODE);
    assign prdata = (paddr[2] == REG_PAD_MODE) ? {29'd0, pad_mode_reg} : 32'd0;

    // Hold the pad mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg <= MODE_NONE;
        end
        else if (cfg_wr)
        begin
            pad_mode_reg <= pwdata[2:0];
        end
    end

    // Move a step into the result stage when the output is free
    assign advance       = !out_valid_reg || m_axis_tready;
    assign take          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Capture an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_pins_reg <= s_axis_tdata[6:0];
        end
    end

    // Decode one poll step
    always_comb
    begin
        step_next = step_reg;
        sel0_next = sel0_reg;
        sel1_next = sel1_reg;
        btn_next  = btn_reg;
        hx_next   = hx_reg;
        hy_next   = hy_reg;
        busy      = 1'b0;
        report    = 1'b0;
        done      = 1'b0;
        abort     = 1'b0;
        prs       = ~in_pins_reg;
        dx        = {1'b0, prs[PIN_RIGHT]} - {1'b0, prs[PIN_LEFT]};
        dy        = {1'b0, prs[PIN_DOWN]} - {1'b0, prs[PIN_UP]};
        k         = step_reg - STEP_SHIFT0;

        if (in_cmd_reg == CMD_START)
        begin
            btn_next = '0;
            hx_next  = '0;
            hy_next  = '0;
            if (pad_mode_reg == MODE_NONE)
            begin
                step_next = STEP_IDLE;
            end
            else
            begin
                step_next = STEP_FIRST;
                busy      = 1'b1;
                if (pad_mode_reg inside {MODE_GEN3, MODE_GEN5, MODE_GEN6})
                begin
                    sel0_next = 1'b1;
                end
            end
        end
        else if (step_reg != STEP_IDLE)
        begin
            case (pad_mode_reg)
                MODE_STICK1, MODE_STICK2, MODE_STICK3:
                begin
                    hx_next = dx;
                    hy_next = dy;
                    if (prs[PIN_FIRE1])
                        btn_next = btn_next | BIT_A;
                    if (prs[PIN_FIRE2] && pad_mode_reg != MODE_STICK1)
                        btn_next = btn_next | BIT_B;
                    if (prs[PIN_FIRE3] && pad_mode_reg == MODE_STICK3)
                        btn_next = btn_next | BIT_C;
                    done = 1'b1;
                end
                MODE_GEN3, MODE_GEN5:
                begin
                    if (step_reg == STEP_FIRST)
                    begin
                        hx_next = dx;
                        hy_next = dy;
                        if (prs[PIN_FIRE1])
                            btn_next = btn_next | BIT_B;
                        if (prs[PIN_FIRE2])
                            btn_next = btn_next | BIT_C;
                        sel0_next = 1'b0;
                    end
                    else if (step_reg == STEP_SECOND)
                    begin
                        if (prs[PIN_FIRE1])
                            btn_next = btn_next | BIT_A;
                        if (pad_mode_reg == MODE_GEN3)
                        begin
                            if (prs[PIN_FIRE2])
                                btn_next = btn_next | BIT_START;
                        end
                        else
                        begin
                            if (prs[PIN_FIRE2])
                                btn_next = btn_next | BIT_X;
                            if (prs[PIN_LEFT])
                                btn_next = btn_next | BIT_Y;
                            if (prs[PIN_RIGHT])
                                btn_next = btn_next | BIT_START;
                        end
                        done = 1'b1;
                    end
                    else
                    begin
                        abort = 1'b1;
                    end
                end
                MODE_GEN6:
                begin
                    if (step_reg == STEP_FIRST)
                    begin
                        hx_next = dx;
                        hy_next = dy;
                        if (prs[PIN_FIRE1])
                            btn_next = btn_next | BIT_B;
                        if (prs[PIN_FIRE2])
                            btn_next = btn_next | BIT_C;
                    end
                    else if (step_reg == STEP_SECOND)
                    begin
                        if (prs[PIN_FIRE1])
                            btn_next = btn_next | BIT_A;
                        if (prs[PIN_FIRE2])
                            btn_next = btn_next | BIT_START;
                    end
                    else if (step_reg == STEP_G6_EXTRA)
                    begin
                        if (prs[PIN_LEFT])
                            btn_next = btn_next | BIT_X;
                        if (prs[PIN_DOWN])
                            btn_next = btn_next | BIT_Y;
                        if (prs[PIN_UP])
                            btn_next = btn_next | BIT_Z;
                        if (prs[PIN_RIGHT])
                            btn_next = btn_next | BIT_MODE;
                    end
                    if (step_reg > STEP_G6_LAST)
                    begin
                        abort = 1'b1;
                    end
                    else
                    begin
                        // odd steps drive low, even steps drive high
                        sel0_next = ~step_reg[0];
                        done      = (step_reg == STEP_G6_LAST);
                    end
                end
                MODE_CD32:
                begin
                    if (step_reg == STEP_FIRST)
                    begin
                        hx_next   = dx;
                        hy_next   = dy;
                        sel0_next = 1'b1;
                    end
                    else if (step_reg == STEP_SECOND)
                    begin
                        sel0_next = 1'b0;
                    end
                    else if (step_reg <= STEP_CD32_LAST)
                    begin
                        // read a button and lower the clock on even shift steps, raise it on odd ones
                        if (!k[0])
                        begin
                            if (prs[PIN_FIRE1])
                                btn_next = btn_next | cd32_bit(k[3:1]);
                            sel1_next = 1'b0;
                        end
                        else
                        begin
                            sel1_next = 1'b1;
                        end
                        done = (step_reg == STEP_CD32_LAST);
                    end
                    else
                    begin
                        abort = 1'b1;
                    end
                end
                default:
                begin
                    abort = 1'b1;
                end
            endcase

            if (done)
            begin
                step_next = STEP_IDLE;
                report    = 1'b1;
            end
            else if (abort)
            begin
                step_next = STEP_IDLE;
            end
            else
            begin
                step_next = step_reg + 5'd1;
                busy      = 1'b1;
            end
        end

        res_data = {report ? btn_next : 10'd0,
                    report ? hy_next  : 2'd0,
                    report ? hx_next  : 2'd0,
                    busy, sel1_next, sel0_next};
    end

    // Advance the poll state on each step taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            sel0_reg <= 1'b0;
            sel1_reg <= 1'b1;
            btn_reg  <= '0;
            hx_reg   <= '0;
            hy_reg   <= '0;
        end
        else if (take)
        begin
            step_reg <= step_next;
            sel0_reg <= sel0_next;
            sel1_reg <= sel1_next;
            btn_reg  <= btn_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg   <= res_data;
            out_report_reg <= report;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};
    assign m_axis_tuser  = out_report_reg;

endmodule

`default_nettype wire
